// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wsfp_pkg.sv -----
// Types, constants and helper functions of the WebSocket frame parser.
`timescale 1ns / 1ps

package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASKKEY,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_FRAGMENT = 2'd1;
  localparam logic [1:0] ST_BADOP    = 2'd2;
  localparam logic [1:0] ST_TOOLONG  = 2'd3;

  localparam logic [6:0] LEN_CODE_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16       = 7'd126;
  localparam logic [6:0] LEN_CODE_64       = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  localparam int         CFG_ADDR_W    = 3;
  localparam logic [0:0] REG_MAX_LEN   = 1'b0;
  localparam logic [31:0] MAX_LEN_RESET = 32'd10485760;

  typedef struct packed {
    logic [7:0] stream_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [3:0]  frame_opcode;
    logic [31:0] decoded_length;
  } result_item_t;

  function automatic logic opcode_bad(input logic [3:0] op);
    return ((op >= 4'd3) && (op <= 4'd7)) || (op >= 4'd11);
  endfunction

  function automatic logic [1:0] end_status(input logic [3:0] op, input logic fin);
    logic [1:0] st;
    if (opcode_bad(op)) begin
      st = ST_BADOP;
    end else if ((op <= 4'd2) && !fin) begin
      st = ST_FRAGMENT;
    end else begin
      st = ST_COMPLETE;
    end
    return st;
  endfunction

endpackage

// ----- rtl/wsfp_stream_if.sv -----
// Valid/ready channel interface that carries one request of a given item type.
`timescale 1ns / 1ps

interface wsfp_stream_if #(parameter type item_t = logic [7:0]) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/websocket_frame_parser.sv -----
// Top level of the WebSocket frame parser: header decode, unmasking and result register.
// A result is registered when its byte is accepted and appears on the output channel in the cycle after.
// Throughput: one byte per cycle unless stalled; each byte passes through a single decode stage.
// The input stalls only while a pending result waits and the output is not ready.
// Reset clears the parse state, drops any pending result and sets the length limit
// to 10485760; a bad opcode or a too-long 64-bit-form frame halts parsing until the next reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_parser import wsfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  wsfp_stream_if.sink           bytes,
  wsfp_stream_if.source         results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] max_len;

  wsfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  phase_t      phase, phase_next;
  logic [3:0]  length_bytes_left, length_bytes_left_next;
  logic [63:0] length_accumulator, length_accumulator_next;
  logic        long_form, long_form_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_byte_index, mask_byte_index_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] frame_length_held, frame_length_held_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_fin, held_fin_next;
  logic        held_masked, held_masked_next;

  logic         res_valid;
  result_item_t res_item;
  result_item_t res_item_next;
  logic         emit;
  logic         fire;

  logic [7:0]  b;
  logic [6:0]  code;
  logic [63:0] acc_shift;
  logic        too_long;
  logic        ext_last;
  logic        hdr_done;
  logic        too_long_hit;
  logic [31:0] new_len;
  logic        masked_now;
  logic        start_pay;
  logic [31:0] start_len;
  logic        zero_finish;
  logic        pay_finish;
  logic        finish;
  logic [31:0] rem_dec;
  logic [4:0]  key_shift;
  logic [31:0] key_word;
  logic [7:0]  unmasked;
  logic [1:0]  status_now;

  assign bytes.ready     = !res_valid || results.ready;
  assign fire            = bytes.valid && bytes.ready;
  assign results.valid   = res_valid;
  assign results.payload = res_item;

  // Decode of the current byte against the parse state.
  always_comb begin
    b           = bytes.payload.stream_byte;
    code        = b[6:0];
    acc_shift   = {length_accumulator[55:0], b};
    too_long    = (acc_shift[63:32] != 32'd0) || (acc_shift[31:0] > max_len);
    ext_last    = (length_bytes_left == 4'd1);
    hdr_done    = ((phase == PH_HDR1) && (code <= LEN_CODE_MAX_SHORT)) ||
                  ((phase == PH_EXTLEN) && ext_last && !(long_form && too_long));
    too_long_hit = (phase == PH_EXTLEN) && ext_last && long_form && too_long;
    new_len     = (phase == PH_HDR1) ? {25'd0, code} : acc_shift[31:0];
    masked_now  = (phase == PH_HDR1) ? b[7] : held_masked;
    start_pay   = (hdr_done && !masked_now) ||
                  ((phase == PH_MASKKEY) && (mask_byte_index == 2'd3));
    start_len   = hdr_done ? new_len : frame_length_held;
    zero_finish = start_pay && (start_len == 32'd0);
    rem_dec     = payload_remaining - 32'd1;
    pay_finish  = (phase == PH_PAYLOAD) && (rem_dec == 32'd0);
    finish      = zero_finish || pay_finish;
    key_shift   = {2'd3 - mask_byte_index, 3'd0};
    key_word    = mask_key >> key_shift;
    unmasked    = b ^ key_word[7:0];
    status_now  = end_status(held_opcode, held_fin);
  end

  // Next parse state and datapath registers.
  always_comb begin
    phase_next              = phase;
    length_bytes_left_next  = length_bytes_left;
    length_accumulator_next = length_accumulator;
    long_form_next          = long_form;
    mask_key_next           = mask_key;
    mask_byte_index_next    = mask_byte_index;
    payload_remaining_next  = payload_remaining;
    frame_length_held_next  = frame_length_held;
    held_opcode_next        = held_opcode;
    held_fin_next           = held_fin;
    held_masked_next        = held_masked;

    unique case (phase)
      PH_HDR0: begin
        held_opcode_next = b[3:0];
        held_fin_next    = b[7];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        held_masked_next = b[7];
        if (code > LEN_CODE_MAX_SHORT) begin
          length_accumulator_next = 64'd0;
          length_bytes_left_next  = (code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          long_form_next          = (code == LEN_CODE_64);
          phase_next              = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        length_accumulator_next = acc_shift;
        length_bytes_left_next  = length_bytes_left - 4'd1;
        if (too_long_hit) begin
          phase_next = PH_HALTED;
        end
      end
      PH_MASKKEY: begin
        mask_key_next        = {mask_key[23:0], b};
        mask_byte_index_next = mask_byte_index + 2'd1;
      end
      PH_PAYLOAD: begin
        mask_byte_index_next   = mask_byte_index + 2'd1;
        payload_remaining_next = rem_dec;
      end
      PH_HALTED: begin
        phase_next = PH_HALTED;
      end
      default: begin
        phase_next = PH_HALTED;
      end
    endcase

    if (hdr_done) begin
      frame_length_held_next = new_len;
      mask_key_next          = 32'd0;
      mask_byte_index_next   = 2'd0;
      if (masked_now) begin
        phase_next = PH_MASKKEY;
      end
    end
    if (start_pay) begin
      payload_remaining_next = start_len;
      mask_byte_index_next   = 2'd0;
      phase_next             = PH_PAYLOAD;
    end
    if (finish) begin
      phase_next = (status_now == ST_BADOP) ? PH_HALTED : PH_HDR0;
    end
  end

  // Result produced by the current byte.
  always_comb begin
    emit                         = finish || too_long_hit || (phase == PH_PAYLOAD);
    res_item_next.payload_byte   = (phase == PH_PAYLOAD) ? unmasked : 8'd0;
    res_item_next.has_byte       = (phase == PH_PAYLOAD);
    res_item_next.frame_end      = finish || too_long_hit;
    res_item_next.frame_opcode   = held_opcode;
    res_item_next.decoded_length = (too_long_hit || zero_finish) ? 32'd0 : frame_length_held;
    priority if (too_long_hit) begin
      res_item_next.frame_status = ST_TOOLONG;
    end else if (finish) begin
      res_item_next.frame_status = status_now;
    end else begin
      res_item_next.frame_status = ST_COMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HDR0;
      length_bytes_left  <= 4'd0;
      length_accumulator <= 64'd0;
      long_form          <= 1'b0;
      mask_key           <= 32'd0;
      mask_byte_index    <= 2'd0;
      payload_remaining  <= 32'd0;
      frame_length_held  <= 32'd0;
      held_opcode        <= 4'd0;
      held_fin           <= 1'b0;
      held_masked        <= 1'b0;
    end else if (fire) begin
      phase              <= phase_next;
      length_bytes_left  <= length_bytes_left_next;
      length_accumulator <= length_accumulator_next;
      long_form          <= long_form_next;
      mask_key           <= mask_key_next;
      mask_byte_index    <= mask_byte_index_next;
      payload_remaining  <= payload_remaining_next;
      frame_length_held  <= frame_length_held_next;
      held_opcode        <= held_opcode_next;
      held_fin           <= held_fin_next;
      held_masked        <= held_masked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= emit;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_item <= res_item_next;
    end
  end

  `ASSERT_NEXT(a_halt_sticky, phase == PH_HALTED, phase == PH_HALTED, "parser left halt")
  `ASSERT_HOLDS(a_status_at_end, res_valid |-> (res_item.frame_end || res_item.frame_status == ST_COMPLETE), "status mid-frame")
  `ASSERT_HOLDS(a_toolong_shape, (res_valid && res_item.frame_status == ST_TOOLONG) |-> (!res_item.has_byte && res_item.decoded_length == 32'd0), "bad too-long result")
  `ASSERT_HOLDS(a_payload_count, (phase == PH_PAYLOAD) |-> (payload_remaining != 32'd0), "payload phase with no bytes left")

endmodule

// ----- rtl/wsfp_cfg.sv -----
// APB register block holding the largest accepted 64-bit-form frame length.
`timescale 1ns / 1ps

module wsfp_cfg import wsfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [31:0]           max_len
);

  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_MAX_LEN);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? max_len : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (wr_en) begin
      max_len <= pwdata;
    end
  end

endmodule
